// ----- rtl/srr_pkg.sv -----
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants for the specular ray reflector
// Field widths, beat structs and the payloads passed between the pipe sections.
// ----------------------------------------------------------------------------
package srr_pkg;

  localparam int DIR_W  = 16;                               // Q2.14 directions
  localparam int VEL_W  = 32;                               // Q16.16 velocities
  localparam int DIR_F  = DIR_W - 2;                        // direction fraction bits
  localparam int VEL_SH = (VEL_W > 32) ? VEL_W - 32 : 0;    // pre-shift for speed
  localparam int VM_W   = VEL_W - VEL_SH;                   // shifted |v| width
  localparam int SQ_W   = (DIR_W > VM_W) ? DIR_W : VM_W;    // root width
  localparam int RAD_W  = 2 * SQ_W;                         // radicand width

  typedef logic signed [DIR_W-1:0] dir_t;
  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic [RAD_W-1:0]        rad_t;
  typedef logic [SQ_W-1:0]         root_t;

  localparam dir_t DIR_MAX = dir_t'({1'b0, {(DIR_W-1){1'b1}}});
  localparam dir_t DIR_MIN = dir_t'({1'b1, {(DIR_W-1){1'b0}}});

  typedef struct packed {
    dir_t dir_x;
    dir_t dir_y;
    dir_t dir_z;
    dir_t norm_x;
    dir_t norm_y;
    dir_t norm_z;
    vel_t vel_x;
    vel_t vel_y;
    vel_t vel_z;
    logic ray_alive;
  } ray_in_t;

  typedef struct packed {
    dir_t out_dir_x;
    dir_t out_dir_y;
    dir_t out_dir_z;
    vel_t out_vel_x;
    vel_t out_vel_y;
    vel_t out_vel_z;
  } ray_out_t;

  // original beat plus the saturated reflected vector
  typedef struct packed {
    ray_in_t    ray;
    dir_t [2:0] r;
  } refl_t;

  typedef struct packed {
    refl_t refl;
    rad_t  rsum;    // sum of r_i^2
    rad_t  vsum;    // sum of (|v_i| >> VEL_SH)^2
  } sq_in_t;

  typedef struct packed {
    refl_t refl;
    root_t mag;
    root_t speed;
  } sq_out_t;

endpackage

// ----- rtl/srr_front.sv -----
// ----------------------------------------------------------------------------
// srr_front: dot product, reflection and squared lengths
// Six stages: d*n, dot round/clamp, dot*n, reflect/clamp, squares, sums.
// ----------------------------------------------------------------------------
module srr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srr_pkg::ray_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output srr_pkg::sq_in_t  out_data
);
  import srr_pkg::*;

  localparam int NST = 6;
  localparam int PW  = 2 * DIR_W;
  localparam int SW  = 2 * DIR_W + 2;
  localparam logic signed [SW-1:0] RND  = SW'(64'sd1 << (DIR_F - 1));
  localparam logic signed [SW-1:0] SMAX = SW'(DIR_MAX);
  localparam logic signed [SW-1:0] SMIN = SW'(DIR_MIN);

  function automatic dir_t sat_dir(input logic signed [SW-1:0] x);
    if (x > SMAX) return DIR_MAX;
    if (x < SMIN) return DIR_MIN;
    return x[DIR_W-1:0];
  endfunction

  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  ray_in_t        ray_r [NST];

  logic signed [PW-1:0] p_r [3], p_nxt [3];
  dir_t                 dot_r, dot_nxt;
  logic signed [PW-1:0] dn_r [3], dn_nxt [3];
  dir_t [2:0]           ra_r, ra_nxt, rb_r, rc_r;
  logic [PW-1:0]        rsq_r [3], rsq_nxt [3];
  logic [2*VM_W-1:0]    vsq_r [3], vsq_nxt [3];
  rad_t                 rsum_r, rsum_nxt, vsum_r, vsum_nxt;

  dir_t d_in [3], n_in [3], n_s2 [3], d_s3 [3];
  vel_t v_s4 [3];

  // ready ripples back through empty stages
  always_comb begin
    en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  assign d_in = '{in_data.dir_x, in_data.dir_y, in_data.dir_z};
  assign n_in = '{in_data.norm_x, in_data.norm_y, in_data.norm_z};
  assign n_s2 = '{ray_r[1].norm_x, ray_r[1].norm_y, ray_r[1].norm_z};
  assign d_s3 = '{ray_r[2].dir_x, ray_r[2].dir_y, ray_r[2].dir_z};
  assign v_s4 = '{ray_r[3].vel_x, ray_r[3].vel_y, ray_r[3].vel_z};

  always_comb begin
    logic signed [SW-1:0] dsum;
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] rr;
    logic [DIR_W-1:0]     a;
    logic [VEL_W-1:0]     va;
    logic [VM_W-1:0]      vm;
    for (int i = 0; i < 3; i++) p_nxt[i] = d_in[i] * n_in[i];
    // round half up over the exact sum, then clamp
    dsum    = SW'(p_r[0]) + SW'(p_r[1]) + SW'(p_r[2]) + RND;
    dot_nxt = sat_dir(dsum >>> DIR_F);
    for (int i = 0; i < 3; i++) dn_nxt[i] = dot_r * n_s2[i];
    for (int i = 0; i < 3; i++) begin
      t         = (SW'(dn_r[i]) + RND) >>> DIR_F;
      rr        = SW'(d_s3[i]) - (t <<< 1);
      ra_nxt[i] = sat_dir(rr);
    end
    for (int i = 0; i < 3; i++) begin
      a          = ra_r[i][DIR_W-1] ? (~ra_r[i] + 1'b1) : ra_r[i];
      rsq_nxt[i] = a * a;
      va         = v_s4[i][VEL_W-1] ? (~v_s4[i] + 1'b1) : v_s4[i];
      vm         = VM_W'(va >> VEL_SH);
      vsq_nxt[i] = vm * vm;
    end
    rsum_nxt = RAD_W'(rsq_r[0]) + RAD_W'(rsq_r[1]) + RAD_W'(rsq_r[2]);
    vsum_nxt = RAD_W'(vsq_r[0]) + RAD_W'(vsq_r[1]) + RAD_W'(vsq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ray_r[0] <= in_data;
      p_r      <= p_nxt;
    end
    if (en[1]) begin
      ray_r[1] <= ray_r[0];
      dot_r    <= dot_nxt;
    end
    if (en[2]) begin
      ray_r[2] <= ray_r[1];
      dn_r     <= dn_nxt;
    end
    if (en[3]) begin
      ray_r[3] <= ray_r[2];
      ra_r     <= ra_nxt;
    end
    if (en[4]) begin
      ray_r[4] <= ray_r[3];
      rb_r     <= ra_r;
      rsq_r    <= rsq_nxt;
      vsq_r    <= vsq_nxt;
    end
    if (en[5]) begin
      ray_r[5] <= ray_r[4];
      rc_r     <= rb_r;
      rsum_r   <= rsum_nxt;
      vsum_r   <= vsum_nxt;
    end
  end

  assign out_valid          = v_r[NST-1];
  assign out_data.refl.ray  = ray_r[NST-1];
  assign out_data.refl.r    = rc_r;
  assign out_data.rsum      = rsum_r;
  assign out_data.vsum      = vsum_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("front blocked input with a bubble in the pipe");

endmodule

// ----- rtl/srr_sqrt.sv -----
// ----------------------------------------------------------------------------
// srr_sqrt: dual pipelined integer square root
// One root bit per stage for |r| and for the speed, side data rides along.
// ----------------------------------------------------------------------------
module srr_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srr_pkg::sq_in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output srr_pkg::sq_out_t out_data
);
  import srr_pkg::*;

  localparam int NST = SQ_W;
  localparam int TW  = RAD_W + 1;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  refl_t          refl_r [NST];
  logic [TW-1:0]  rrem_r [NST], vrem_r [NST];
  root_t          rq_r [NST], vq_r [NST];

  always_comb begin
    en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_st
    localparam int B = NST - 1 - k;
    logic [TW-1:0] rrem_i, vrem_i, rtr, vtr;
    root_t         rq_i, vq_i;
    refl_t         refl_i;

    if (k == 0) begin : g_first
      assign rrem_i = TW'(in_data.rsum);
      assign vrem_i = TW'(in_data.vsum);
      assign rq_i   = '0;
      assign vq_i   = '0;
      assign refl_i = in_data.refl;
    end else begin : g_next
      assign rrem_i = rrem_r[k-1];
      assign vrem_i = vrem_r[k-1];
      assign rq_i   = rq_r[k-1];
      assign vq_i   = vq_r[k-1];
      assign refl_i = refl_r[k-1];
    end

    // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
    assign rtr = (TW'(rq_i) << (B + 1)) | (TW'(1) << (2 * B));
    assign vtr = (TW'(vq_i) << (B + 1)) | (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en[k]) begin
        refl_r[k] <= refl_i;
        if (rrem_i >= rtr) begin
          rrem_r[k] <= rrem_i - rtr;
          rq_r[k]   <= rq_i | (root_t'(1) << B);
        end else begin
          rrem_r[k] <= rrem_i;
          rq_r[k]   <= rq_i;
        end
        if (vrem_i >= vtr) begin
          vrem_r[k] <= vrem_i - vtr;
          vq_r[k]   <= vq_i | (root_t'(1) << B);
        end else begin
          vrem_r[k] <= vrem_i;
          vq_r[k]   <= vq_i;
        end
      end
    end
  end

  assign out_valid      = v_r[NST-1];
  assign out_data.refl  = refl_r[NST-1];
  assign out_data.mag   = rq_r[NST-1];
  assign out_data.speed = vq_r[NST-1];

  // floor root: leftover x - q^2 never exceeds 2q
  a_mag_root: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] |-> rrem_r[NST-1] <= (TW'(rq_r[NST-1]) << 1))
    else $error("length root not the floor root");
  a_spd_root: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NST-1] |-> vrem_r[NST-1] <= (TW'(vq_r[NST-1]) << 1))
    else $error("speed root not the floor root");
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("root pipe blocked input with a bubble in the pipe");

endmodule

// ----- rtl/srr_back.sv -----
// ----------------------------------------------------------------------------
// srr_back: renormalize and scale
// Restoring divide one quotient bit per stage, speed multiply, round, saturate.
// ----------------------------------------------------------------------------
module srr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srr_pkg::sq_out_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srr_pkg::ray_out_t out_data
);
  import srr_pkg::*;

  localparam int NW  = 2 * DIR_W;              // dividend width
  localparam int MW  = DIR_W - 1;              // quotient width, top is overflow
  localparam int PRW = SQ_W + MW;              // speed * |q|
  localparam int FW  = PRW + VEL_SH + 1;
  localparam int MI  = DIR_W + 1;              // multiply stage
  localparam int FI  = DIR_W + 2;              // output stage
  localparam int NST = DIR_W + 3;
  localparam logic [FW-1:0] VLIM = FW'({(VEL_W-1){1'b1}});
  localparam logic [FW-1:0] VRND = FW'(1) << (DIR_F - 1);

  typedef struct packed {
    refl_t                refl;
    logic [DIR_W-1:0]     mag;
    root_t                speed;
    logic [2:0][NW-1:0]   rem;
    logic [2:0][MW-1:0]   q;
    logic [2:0]           ov;
  } dv_t;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  dv_t            dv_r [DIR_W+1];
  dv_t            dv0_nxt;

  ray_in_t        ray_m_r;
  logic           zero_m_r;
  logic [2:0]     neg_m_r, neg_nxt;
  logic [MW-1:0]  m_m_r [3], m_nxt [3];
  logic [PRW-1:0] prod_m_r [3], prod_nxt [3];
  ray_out_t       out_r, out_nxt;

  always_comb begin
    en[NST] = out_ready;
    for (int k = NST - 1; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end
  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) if (en[k]) v_r[k] <= v_r[k-1];
    end
  end

  // dividend |r|*2^F + mag/2 gives round-half-up quotient; mag fits DIR_W bits
  always_comb begin
    logic [DIR_W-1:0] a;
    dv0_nxt.refl  = in_data.refl;
    dv0_nxt.mag   = in_data.mag[DIR_W-1:0];
    dv0_nxt.speed = in_data.speed;
    dv0_nxt.q     = '0;
    dv0_nxt.ov    = '0;
    for (int i = 0; i < 3; i++) begin
      a = in_data.refl.r[i][DIR_W-1] ? (~in_data.refl.r[i] + 1'b1) : in_data.refl.r[i];
      dv0_nxt.rem[i] = (NW'(a) << DIR_F) + NW'(in_data.mag[DIR_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) dv_r[0] <= dv0_nxt;
  end

  for (genvar k = 1; k <= DIR_W; k++) begin : g_div
    localparam int B = DIR_W - k;
    dv_t cur, nxt;
    if (k == 1) begin : g_ovf
      // quotient of 2^(DIR_W-1) or more saturates
      always_comb begin
        cur = dv_r[k-1];
        nxt = cur;
        for (int i = 0; i < 3; i++)
          nxt.ov[i] = cur.rem[i] >= (NW'(cur.mag) << B);
      end
    end else begin : g_bit
      always_comb begin
        cur = dv_r[k-1];
        nxt = cur;
        for (int i = 0; i < 3; i++) begin
          if (cur.rem[i] >= (NW'(cur.mag) << B)) begin
            nxt.rem[i]  = cur.rem[i] - (NW'(cur.mag) << B);
            nxt.q[i][B] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[k]) dv_r[k] <= nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_nxt[i]    = dv_r[DIR_W].ov[i] ? DIR_MAX[MW-1:0] : dv_r[DIR_W].q[i];
      neg_nxt[i]  = dv_r[DIR_W].refl.r[i][DIR_W-1];
      prod_nxt[i] = dv_r[DIR_W].speed * m_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en[MI]) begin
      ray_m_r  <= dv_r[DIR_W].refl.ray;
      zero_m_r <= dv_r[DIR_W].mag == '0;
      neg_m_r  <= neg_nxt;
      m_m_r    <= m_nxt;
      prod_m_r <= prod_nxt;
    end
  end

  always_comb begin
    logic [FW-1:0]    val;
    logic [FW-1:0]    lim;
    logic [DIR_W-1:0] dm;
    dir_t [2:0]       od;
    vel_t [2:0]       ov;
    for (int i = 0; i < 3; i++) begin
      val   = ((FW'(prod_m_r[i]) << VEL_SH) + VRND) >> DIR_F;
      lim   = VLIM + FW'(neg_m_r[i]);
      if (val > lim) val = lim;
      dm    = {1'b0, m_m_r[i]};
      od[i] = neg_m_r[i] ? (~dm + 1'b1) : dm;
      ov[i] = neg_m_r[i] ? VEL_W'(~val + 1'b1) : VEL_W'(val);
    end
    if (!ray_m_r.ray_alive) begin
      out_nxt.out_dir_x = ray_m_r.dir_x;
      out_nxt.out_dir_y = ray_m_r.dir_y;
      out_nxt.out_dir_z = ray_m_r.dir_z;
      out_nxt.out_vel_x = ray_m_r.vel_x;
      out_nxt.out_vel_y = ray_m_r.vel_y;
      out_nxt.out_vel_z = ray_m_r.vel_z;
    end else if (zero_m_r) begin
      out_nxt = '0;
    end else begin
      out_nxt.out_dir_x = od[0];
      out_nxt.out_dir_y = od[1];
      out_nxt.out_dir_z = od[2];
      out_nxt.out_vel_x = ov[0];
      out_nxt.out_vel_y = ov[1];
      out_nxt.out_vel_z = ov[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[FI]) out_r <= out_nxt;
  end

  assign out_valid = v_r[FI];
  assign out_data  = out_r;

  for (genvar i = 0; i < 3; i++) begin : g_chk
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
      v_r[DIR_W] && (dv_r[DIR_W].mag != '0) && !dv_r[DIR_W].ov[i]
      |-> dv_r[DIR_W].rem[i] < NW'(dv_r[DIR_W].mag))
      else $error("divider remainder not below divisor");
  end
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("back end blocked input with a bubble in the pipe");

endmodule

// ----- rtl/specular_ray_reflect.sv -----
// ----------------------------------------------------------------------------
// specular_ray_reflect: specular reflection of a ray at a boundary
// Reflects a unit direction about a unit normal, renormalizes it and scales
// the old speed onto it. Dead rays pass through unchanged.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per ray hit (direction, normal Q2.14; velocity Q16.16,
//           alive flag) on a valid/ready channel.
//   out_* : one beat per input beat, in order, same valid/ready handshake.
//   The pipe: 6 front stages (dot product, reflect, squares), 32 root stages
//   (one root bit each for |r| and the speed), 1 dividend stage, 16 divide
//   stages (an overflow check, then one quotient bit each), multiply, output.
//   Throughput is one beat per clock while out_ready is high; the 32-stage
//   root pipe sets the depth, the 16-stage divider the second largest share.
//   Reset (rst_n low at a clock edge) clears every stage valid bit; the pipe
//   is empty and ready on the next cycle. No payload is reset.
//   When out_ready is low the output holds; empty stages upstream keep
//   filling, so in_ready only drops once every stage holds a beat.
//   Zero-length reflection gives an all-zero result; velocities saturate.
// ----------------------------------------------------------------------------
module specular_ray_reflect (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  srr_pkg::ray_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output srr_pkg::ray_out_t out_data
);
  import srr_pkg::*;

  // front -> root pipe
  logic    f_valid, f_ready;
  sq_in_t  f_data;
  // root pipe -> back end
  logic    s_valid, s_ready;
  sq_out_t s_data;

  srr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  srr_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  srr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- tb/specular_ray_reflect_tb.sv -----
// ----------------------------------------------------------------------------
// specular_ray_reflect_tb: self-checking bench for the specular ray reflector
// Drives directed and random ray hits through valid/ready with random gaps
// and stalls, predicts every result in fixed point and compares field by
// field, in order.
// ----------------------------------------------------------------------------
module specular_ray_reflect_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srr_pkg::*;

  localparam int LATENCY   = 57;
  localparam int CYCLE_CAP = 400000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  ray_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  ray_out_t out_data;

  ray_out_t expected_rays[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  bit       src_idle_on = 1'b1;   // random gaps on the sender side
  bit       sink_idle_on = 1'b1;  // random stalls on the receiver side
  int       sink_hold = 0;        // cycles the receiver still holds off

  specular_ray_reflect dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_rng(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_out_t reflect_ray(ray_in_t b);
    ray_out_t        o;
    longint          d[3], n[3], v[3], r[3], q[3];
    longint          dsum, dot, t;
    longint unsigned rsum, vsum, mag, speed, a, m, lim;
    logic [127:0]    prod;
    o = '0;
    if (!b.ray_alive) begin
      o.out_dir_x = b.dir_x;  o.out_dir_y = b.dir_y;  o.out_dir_z = b.dir_z;
      o.out_vel_x = b.vel_x;  o.out_vel_y = b.vel_y;  o.out_vel_z = b.vel_z;
      return o;
    end
    d[0] = b.dir_x;  d[1] = b.dir_y;  d[2] = b.dir_z;
    n[0] = b.norm_x; n[1] = b.norm_y; n[2] = b.norm_z;
    v[0] = b.vel_x;  v[1] = b.vel_y;  v[2] = b.vel_z;
    // exact dot sum, round half up
    dsum = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
    dot = sat_rng((dsum + (64'sd1 <<< (DIR_F - 1))) >>> DIR_F, DIR_MIN, DIR_MAX);
    rsum = 0;
    for (int i = 0; i < 3; i++) begin
      t = (dot * n[i] + (64'sd1 <<< (DIR_F - 1))) >>> DIR_F;
      r[i] = sat_rng(d[i] - 2 * t, DIR_MIN, DIR_MAX);
      a = (r[i] < 0) ? -r[i] : r[i];
      rsum += a * a;
    end
    mag = int_sqrt(rsum);
    if (mag == 0) return o;  // zero-length reflection
    for (int i = 0; i < 3; i++) begin
      a = (r[i] < 0) ? -r[i] : r[i];
      m = ((a << DIR_F) + (mag >> 1)) / mag;
      if (m > DIR_MAX) m = DIR_MAX;
      q[i] = (r[i] < 0) ? -longint'(m) : longint'(m);
    end
    vsum = 0;
    for (int i = 0; i < 3; i++) begin
      a = ((v[i] < 0) ? -v[i] : v[i]) >> VEL_SH;
      vsum += a * a;
    end
    speed = int_sqrt(vsum) << VEL_SH;
    for (int i = 0; i < 3; i++) begin
      a = (q[i] < 0) ? -q[i] : q[i];
      lim = ((64'd1 << (VEL_W - 1)) - 1) + ((q[i] < 0) ? 1 : 0);
      prod = (128'(speed) * 128'(a) + (128'd1 << (DIR_F - 1))) >> DIR_F;
      m = (prod > 128'(lim)) ? lim : prod[63:0];
      if (q[i] < 0) m = -m;
      case (i)
        0: begin o.out_dir_x = dir_t'(q[i]); o.out_vel_x = vel_t'(m); end
        1: begin o.out_dir_y = dir_t'(q[i]); o.out_vel_y = vel_t'(m); end
        default: begin o.out_dir_z = dir_t'(q[i]); o.out_vel_z = vel_t'(m); end
      endcase
    end
    return o;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // checks each result beat, in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rays.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          ray_out_t w;
          w = expected_rays.pop_front();
          if (out_data.out_dir_x !== w.out_dir_x)
            report_mismatch("out_dir_x", out_data.out_dir_x, w.out_dir_x);
          if (out_data.out_dir_y !== w.out_dir_y)
            report_mismatch("out_dir_y", out_data.out_dir_y, w.out_dir_y);
          if (out_data.out_dir_z !== w.out_dir_z)
            report_mismatch("out_dir_z", out_data.out_dir_z, w.out_dir_z);
          if (out_data.out_vel_x !== w.out_vel_x)
            report_mismatch("out_vel_x", out_data.out_vel_x, w.out_vel_x);
          if (out_data.out_vel_y !== w.out_vel_y)
            report_mismatch("out_vel_y", out_data.out_vel_y, w.out_vel_y);
          if (out_data.out_vel_z !== w.out_vel_z)
            report_mismatch("out_vel_z", out_data.out_vel_z, w.out_vel_z);
        end
      end
    end
  end

  // receiver readiness: random stalls or a counted hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (sink_hold > 0) begin
        sink_hold <= sink_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(sink_idle_on && $urandom_range(99) < 9);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  // send one beat; valid stays up across back-to-back beats
  task automatic send_ray(ray_in_t b);
    while (src_idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    expected_rays.push_back(reflect_ray(b));
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
  endtask

  function automatic dir_t rand_dir();
    return dir_t'($urandom());
  endfunction

  // random vector near a unit axis: that axis spread by +-1000 LSB, the others up to +-1/2
  function automatic void rand_unit(output dir_t x, output dir_t y, output dir_t z);
    int c[3];
    for (int i = 0; i < 3; i++) c[i] = $urandom_range(16384) - 8192;
    c[$urandom_range(2)] = ($urandom_range(1) ? 16384 : -16384) -
                           int'($urandom_range(2000)) + 1000;
    x = dir_t'(c[0]);  y = dir_t'(c[1]);  z = dir_t'(c[2]);
  endfunction

  function automatic ray_in_t rand_ray(bit wild);
    ray_in_t b;
    if (wild) begin
      b.dir_x = rand_dir();  b.dir_y = rand_dir();  b.dir_z = rand_dir();
      b.norm_x = rand_dir(); b.norm_y = rand_dir(); b.norm_z = rand_dir();
    end else begin
      rand_unit(b.dir_x, b.dir_y, b.dir_z);
      rand_unit(b.norm_x, b.norm_y, b.norm_z);
    end
    case ($urandom_range(3))
      0: begin
        b.vel_x = vel_t'($urandom()); b.vel_y = vel_t'($urandom());
        b.vel_z = vel_t'($urandom());
      end
      default: begin
        b.vel_x = vel_t'(int'($urandom_range(1 << 22)) - (1 << 21));
        b.vel_y = vel_t'(int'($urandom_range(1 << 22)) - (1 << 21));
        b.vel_z = vel_t'(int'($urandom_range(1 << 22)) - (1 << 21));
      end
    endcase
    b.ray_alive = ($urandom_range(9) != 0);
    return b;
  endfunction

  function automatic ray_in_t make_ray(int dx, int dy, int dz, int nx, int ny, int nz,
                                       int vx, int vy, int vz, bit alive);
    ray_in_t b;
    b.dir_x = dir_t'(dx);  b.dir_y = dir_t'(dy);  b.dir_z = dir_t'(dz);
    b.norm_x = dir_t'(nx); b.norm_y = dir_t'(ny); b.norm_z = dir_t'(nz);
    b.vel_x = vel_t'(vx);  b.vel_y = vel_t'(vy);  b.vel_z = vel_t'(vz);
    b.ray_alive = alive;
    return b;
  endfunction

  task automatic test_directed();
    // head-on hit, oblique hit, grazing
    send_ray(make_ray(0, 0, -16384, 0, 0, 16384, 0, 0, -65536, 1));
    send_ray(make_ray(11585, 0, -11585, 0, 0, 16384, 65536, 0, -65536, 1));
    send_ray(make_ray(16384, 0, 0, 0, 0, 16384, 131072, 0, 0, 1));
    // dead rays pass through, extremes
    send_ray(make_ray(-32768, 32767, 0, -32768, 32767, -1,
                      32'h80000000, 32'h7fffffff, -1, 0));
    send_ray(make_ray(32767, -32768, -1, 1, 0, 32767, 0, 32'h80000000, 1, 0));
    // zero-length reflection from a zero direction, then d along n with d.n = 1/2
    send_ray(make_ray(0, 0, 0, 0, 0, 16384, 65536, 0, 0, 1));
    send_ray(make_ray(0, 0, 8192, 0, 0, 16384, 65536, 65536, 0, 1));
    // out-of-range non-unit inputs, saturation everywhere
    send_ray(make_ray(32767, 32767, 32767, 32767, 32767, 32767,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1));
    send_ray(make_ray(-32768, -32768, -32768, -32768, -32768, -32768,
                      32'h80000000, 32'h80000000, 32'h80000000, 1));
    send_ray(make_ray(-32768, 32767, -32768, 32767, -32768, 32767,
                      32'h80000000, 32'h7fffffff, 0, 1));
    send_ray(make_ray(32767, 0, 0, -32768, 0, 0, 32'h7fffffff, 0, 0, 1));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1));
    send_ray(make_ray(1, 0, 0, 0, 1, 0, 1, 0, 0, 1));
    idle_input();
  endtask

  task automatic test_random(int count, int wild_pct);
    for (int k = 0; k < count; k++) send_ray(rand_ray($urandom_range(99) < wild_pct));
    idle_input();
  endtask

  // receiver holds off long enough for the pipe to fill and stall the input
  task automatic test_backpressure();
    sink_hold = 150;
    src_idle_on = 1'b0;
    test_random(120, 20);
    src_idle_on = 1'b1;
  endtask

  task automatic test_streaming();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(150, 20);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 25);
    test_backpressure();
    test_streaming();
    test_random(130, 50);
    while (expected_rays.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_rays.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
